>>> rtl/core/qalu_pkg.sv
// Shared types, opcodes and constants of the Q24.8 fixed-point ALU.
package qalu_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned DVD_W     = DATA_W + FRAC_BITS;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = DVD_W / BITS_PER_STAGE;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_LT    = 4'd4,
    OP_GT    = 4'd5,
    OP_LE    = 4'd6,
    OP_GE    = 4'd7,
    OP_EQ    = 4'd8,
    OP_NE    = 4'd9,
    OP_MIN   = 4'd10,
    OP_MAX   = 4'd11,
    OP_INC   = 4'd12,
    OP_DEC   = 4'd13,
    OP_TOINT = 4'd14,
    OP_NONE  = 4'd15
  } op_e;

  // One beat in flight through the pipeline
  typedef struct packed {
    logic              valid;
    op_e               op;
    logic [DATA_W-1:0] value;
    logic              cmp;
    logic              derr;
    logic              qneg;
    logic [DATA_W-1:0] rem;
    logic [DVD_W-1:0]  dvd;
    logic [DATA_W-1:0] dsr;
  } pipe_t;

endpackage

>>> rtl/core/qalu_pre.sv
// Front stage: decode, simple results, multiplier and divider operand setup.
module qalu_pre (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [3:0]                          opcode_i,
  input  logic signed [qalu_pkg::DATA_W-1:0]  operand_a_i,
  input  logic signed [qalu_pkg::DATA_W-1:0]  operand_b_i,
  output qalu_pkg::pipe_t                     beat_o,
  output logic signed [qalu_pkg::PROD_W-1:0]  prod_o
);

  qalu_pkg::pipe_t                    beat_d, beat_q;
  logic signed [qalu_pkg::PROD_W-1:0] prod_d, prod_q;
  logic [qalu_pkg::DATA_W-1:0]        mag_a, mag_b;
  logic signed [qalu_pkg::DATA_W-1:0] toint_val;
  logic                               lt, eq;

  // Compute simple results and operand magnitudes
  always_comb begin
    lt        = operand_a_i < operand_b_i;
    eq        = operand_a_i == operand_b_i;
    mag_a     = operand_a_i[qalu_pkg::DATA_W-1] ? (~operand_a_i + 1'b1) : operand_a_i;
    mag_b     = operand_b_i[qalu_pkg::DATA_W-1] ? (~operand_b_i + 1'b1) : operand_b_i;
    // Bias negative values so the arithmetic shift truncates toward zero
    toint_val = (operand_a_i + (operand_a_i[qalu_pkg::DATA_W-1] ?
                 qalu_pkg::DATA_W'((1 << qalu_pkg::FRAC_BITS) - 1) :
                 qalu_pkg::DATA_W'(0)))
                >>> qalu_pkg::FRAC_BITS;
    prod_d    = operand_a_i * operand_b_i;

    beat_d       = '0;
    beat_d.valid = start_i;
    beat_d.op    = qalu_pkg::op_e'(opcode_i);
    beat_d.rem   = '0;
    beat_d.dvd   = {mag_a, {qalu_pkg::FRAC_BITS{1'b0}}};
    beat_d.dsr   = mag_b;
    beat_d.qneg  = operand_a_i[qalu_pkg::DATA_W-1] ^ operand_b_i[qalu_pkg::DATA_W-1];
    beat_d.derr  = (beat_d.op == qalu_pkg::OP_DIV) && (operand_b_i == '0);
    case (beat_d.op)
      qalu_pkg::OP_ADD:   beat_d.value = operand_a_i + operand_b_i;
      qalu_pkg::OP_SUB:   beat_d.value = operand_a_i - operand_b_i;
      qalu_pkg::OP_LT:    beat_d.cmp   = lt;
      qalu_pkg::OP_GT:    beat_d.cmp   = !lt && !eq;
      qalu_pkg::OP_LE:    beat_d.cmp   = lt || eq;
      qalu_pkg::OP_GE:    beat_d.cmp   = !lt;
      qalu_pkg::OP_EQ:    beat_d.cmp   = eq;
      qalu_pkg::OP_NE:    beat_d.cmp   = !eq;
      qalu_pkg::OP_MIN:   beat_d.value = lt ? operand_a_i : operand_b_i;
      qalu_pkg::OP_MAX:   beat_d.value = lt ? operand_b_i : operand_a_i;
      qalu_pkg::OP_INC:   beat_d.value = operand_a_i + 1'b1;
      qalu_pkg::OP_DEC:   beat_d.value = operand_a_i - 1'b1;
      qalu_pkg::OP_TOINT: beat_d.value = toint_val;
      default:            beat_d.value = '0;
    endcase
  end

  // Advance the beat and hold its payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
      prod_q <= '0;
    end else begin
      beat_q <= beat_d;
      prod_q <= prod_d;
    end
  end

  assign beat_o = beat_q;
  assign prod_o = prod_q;

endmodule

>>> rtl/core/qalu_div_stage.sv
// One divider stage: restoring division steps on the unsigned magnitudes.
module qalu_div_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  qalu_pkg::pipe_t beat_i,
  output qalu_pkg::pipe_t beat_o
);

  qalu_pkg::pipe_t           beat_d, beat_q;
  logic [qalu_pkg::DATA_W:0] trial;

  // Shift in one dividend bit per step, subtract when the divisor fits
  always_comb begin
    beat_d = beat_i;
    trial  = '0;
    for (int unsigned i = 0; i < qalu_pkg::BITS_PER_STAGE; i++) begin
      trial      = {beat_d.rem, beat_d.dvd[qalu_pkg::DVD_W-1]};
      beat_d.dvd = {beat_d.dvd[qalu_pkg::DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, beat_d.dsr}) begin
        trial         = trial - {1'b0, beat_d.dsr};
        beat_d.dvd[0] = 1'b1;
      end
      beat_d.rem = trial[qalu_pkg::DATA_W-1:0];
    end
  end

  // Advance the beat and hold its payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

>>> rtl/core/fixed_point_q24_8_alu_top.sv
// Top level of the pipelined Q24.8 fixed-point ALU.
//
// Command channel: an operation beat (opcode, operand_a, operand_b) is taken
// at each rising edge with start high and busy low. busy is always low,
// so a new beat may enter in every cycle.
// Result channel: done_o is high for exactly one cycle and qualifies
// result_value_o, compare_true_o and divide_error_o in that cycle.
// Pipeline: every opcode passes through the same registers from the accepting
// edge to the edge that ends the done_o cycle: one front stage (decode and 32x32
// multiplier), one stage that rounds the product toward zero, 20 divider
// stages of two quotient bits each on the 40-bit shifted dividend, and the
// output register. The divider chain sets that depth.
// Throughput: one operation per cycle, results in order of acceptance.
// Reset clears all valid bits, so no result appears until a beat enters.
// The receiver cannot stall: each result shows for one cycle only.
module fixed_point_q24_8_alu_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [3:0]                         opcode_i,
  input  logic signed [qalu_pkg::DATA_W-1:0] operand_a_i,
  input  logic signed [qalu_pkg::DATA_W-1:0] operand_b_i,
  output logic                               done_o,
  output logic signed [qalu_pkg::DATA_W-1:0] result_value_o,
  output logic                               compare_true_o,
  output logic                               divide_error_o
);

  qalu_pkg::pipe_t                    pre_beat;
  logic signed [qalu_pkg::PROD_W-1:0] prod;
  logic signed [qalu_pkg::PROD_W-1:0] prod_adj;
  qalu_pkg::pipe_t                    mul_d, mul_q;
  qalu_pkg::pipe_t                    chain [qalu_pkg::DIV_STAGES+1];
  qalu_pkg::pipe_t                    last;
  logic [qalu_pkg::DVD_W-1:0]         quo;
  logic                               done_d, done_q;
  logic [qalu_pkg::DATA_W-1:0]        value_d, value_q;
  logic                               cmp_q, derr_q;

  assign busy = 1'b0;

  qalu_pre u_pre (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .opcode_i    (opcode_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .beat_o      (pre_beat),
    .prod_o      (prod)
  );

  // Round the product toward zero and merge it into the value
  always_comb begin
    prod_adj = (prod + (prod[qalu_pkg::PROD_W-1] ?
                qalu_pkg::PROD_W'((1 << qalu_pkg::FRAC_BITS) - 1) :
                qalu_pkg::PROD_W'(0)))
               >>> qalu_pkg::FRAC_BITS;
    mul_d = pre_beat;
    if (pre_beat.op == qalu_pkg::OP_MUL) begin
      mul_d.value = prod_adj[qalu_pkg::DATA_W-1:0];
    end
  end

  // Advance the beat and hold its payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q <= '0;
    end else begin
      mul_q <= mul_d;
    end
  end

  // Divider chain
  assign chain[0] = mul_q;
  for (genvar g = 0; g < qalu_pkg::DIV_STAGES; g++) begin : g_div
    qalu_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .beat_i (chain[g]),
      .beat_o (chain[g+1])
    );
  end
  assign last = chain[qalu_pkg::DIV_STAGES];

  // Apply the quotient sign and select the final value
  always_comb begin
    quo     = last.qneg ? (~last.dvd + 1'b1) : last.dvd;
    done_d  = last.valid;
    value_d = last.value;
    if (last.op == qalu_pkg::OP_DIV) begin
      value_d = last.derr ? '0 : quo[qalu_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    cmp_q   <= last.cmp;
    derr_q  <= last.derr;
  end

  assign done_o         = done_q;
  assign result_value_o = value_q;
  assign compare_true_o = cmp_q;
  assign divide_error_o = derr_q;

  // A result beat appears exactly the pipeline depth after a command beat
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##23 1'b1 |-> (done_o == $past(start, 23)))
    else $error("result strobe out of step with accepted commands");

  // A comparison never carries a value
  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && compare_true_o) |-> (result_value_o == '0 && !divide_error_o))
    else $error("comparison result with nonzero value");

  // A divide error always reports zero
  a_derr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && divide_error_o) |-> (result_value_o == '0))
    else $error("divide error with nonzero value");

endmodule
